[hdl/qmd_pkg.sv]
package qmd_pkg;

  // field and register widths
  localparam int CW     = 48;   // coordinate and register width
  localparam int IW     = 32;   // index width
  localparam int QW     = 16;   // quantized coordinate width
  localparam int PW     = 64;   // product width
  localparam int QUOW   = 49;   // scaled magnitude width
  localparam int NLANE  = 3;    // u, v, height
  localparam int LSTG   = 6;    // register stages inside a lane
  localparam int NSTG   = LSTG + 1;
  localparam int CFG_AW = 3;

  // divisor of the scaling and its rounding bias
  localparam int QMAX  = 32767;
  localparam int QHALF = QMAX / 2;

  // opcodes
  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_INDEX  = 2'd1,
    OP_TILE   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_X_OFF  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_Y_OFF  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_Z_OFF  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_X_SPAN = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_Y_SPAN = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_Z_SPAN = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_WIDE   = 3'd6;

  // result kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  // control into each lane
  typedef struct packed {
    logic            step;   // vertex transfer accepted
    logic            clear;  // tile start accepted
    logic [LSTG-1:0] en;     // per-stage advance
  } lane_ctl_t;

  // control into the merging stage
  typedef struct packed {
    logic          en;
    logic          kind;
    logic [IW-1:0] idx;
  } merge_ctl_t;

  // zigzag decode
  function automatic logic [QW-1:0] unzig(input logic [QW-1:0] c);
    unzig = (c >> 1) ^ {QW{c[0]}};
  endfunction

endpackage

[hdl/qmd_lane.sv]
module qmd_lane
  import qmd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  lane_ctl_t       ctl,
  input  logic [QW-1:0]   code,
  input  logic [CW-1:0]   span_mag,
  output logic [QUOW-1:0] quo
);

  logic [QW-1:0]   acc_r, acc_nxt;
  logic [QW-1:0]   q_r;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [PW-1:0]   n_r;
  logic [49:0]     qa_r;
  logic [19:0]     qb_r;
  logic [17:0]     s_r, s_nxt;
  logic [49:0]     q0_r;
  logic [2:0]      ex_r;
  logic [15:0]     sf_r;
  logic [49:0]     quo_nxt;
  logic [QUOW-1:0] quo_r;

  // wrapping accumulator
  assign acc_nxt = acc_r + unzig(code);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= acc_nxt;
    end
  end

  // stage 1: quantized value
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      q_r <= acc_nxt;
    end
  end

  // stage 2: span magnitude times value
  assign prod_nxt = span_mag * q_r;

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      prod_r <= prod_nxt;
    end
  end

  // stage 3: rounding bias
  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      n_r <= prod_r + PW'(QHALF);
    end
  end

  // stage 4: divide by 2^15-1 as shifted sums plus the 15-bit digit sum
  assign s_nxt = 18'(n_r[14:0]) + 18'(n_r[29:15]) + 18'(n_r[44:30])
               + 18'(n_r[59:45]) + 18'(n_r[63:60]);

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      qa_r <= 50'(n_r >> 15) + 50'(n_r >> 30);
      qb_r <= 20'(n_r >> 45) + 20'(n_r >> 60);
      s_r  <= s_nxt;
    end
  end

  // stage 5: fold the digit sum once more
  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      q0_r <= qa_r + 50'(qb_r);
      ex_r <= s_r[17:15];
      sf_r <= 16'(s_r[14:0]) + 16'(s_r[17:15]);
    end
  end

  // stage 6: final correction of the quotient
  assign quo_nxt = q0_r + 50'(ex_r) + 50'(sf_r >= 16'(QMAX));

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      quo_r <= quo_nxt[QUOW-1:0];
    end
  end

  assign quo = quo_r;

endmodule

[hdl/qmd_merge.sv]
module qmd_merge
  import qmd_pkg::*;
(
  input  logic                        clk,
  input  merge_ctl_t                  ctl,
  input  logic [NLANE-1:0][QUOW-1:0]  quo,
  input  logic [NLANE-1:0]            neg,
  input  logic [NLANE-1:0][CW-1:0]    off,
  output logic                        kind,
  output logic [NLANE-1:0][CW-1:0]    coord,
  output logic [IW-1:0]               idx
);

  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic                    kind_r;
  logic [NLANE-1:0][CW-1:0] coord_r, coord_nxt;
  logic [IW-1:0]           idx_r;
  logic [CW+2:0]           sum [NLANE];

  // offset plus signed scaled span, saturated; index results carry zeros
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      if (neg[i]) begin
        sum[i] = {{3{off[i][CW-1]}}, off[i]} - {2'b00, quo[i]};
      end else begin
        sum[i] = {{3{off[i][CW-1]}}, off[i]} + {2'b00, quo[i]};
      end
      if (ctl.kind == KIND_INDEX) begin
        coord_nxt[i] = '0;
      end else if (sum[i][CW+2:CW-1] == 4'b0000 || sum[i][CW+2:CW-1] == 4'b1111) begin
        coord_nxt[i] = sum[i][CW-1:0];
      end else if (sum[i][CW+2]) begin
        coord_nxt[i] = SAT_MIN;
      end else begin
        coord_nxt[i] = SAT_MAX;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      kind_r  <= ctl.kind;
      coord_r <= coord_nxt;
      idx_r   <= (ctl.kind == KIND_INDEX) ? ctl.idx : '0;
    end
  end

  assign kind  = kind_r;
  assign coord = coord_r;
  assign idx   = idx_r;

endmodule

[hdl/quantized_mesh_decoder_core.sv]
// channel  | handshake          | payload
// ---------+--------------------+----------------------------------------------
// in       | in_tvalid/tready   | tuser: opcode; tdata: u, v, h, index code
// out      | out_tvalid/tready  | tuser: kind; tdata: x, y, z, vertex index
// cfg      | cfg_we             | cfg_addr register index, cfg_wdata value
//
// one item per cycle sustained while out_tready stays high; a result passes the
// six stages per coordinate lane, set by the multiply and divide-by-32767 chain,
// then the merging output register
// rst_n is synchronous: clears accumulators, high-water mark, configuration registers, valids
// stalls collapse bubbles stage by stage; in_tready falls only when all seven
// stages hold results and out_tready is low
module quantized_mesh_decoder_core
  import qmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [79:0]       in_tdata,   // u_code, v_code, h_code, index_code
  input  logic [1:0]        in_tuser,   // opcode
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [175:0]      out_tdata,  // x_out, y_out, z_out, vertex_index
  output logic              out_tuser,  // kind
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CW-1:0]     cfg_wdata
);

  logic [NLANE-1:0][CW-1:0]   off_r;
  logic [NLANE-1:0][CW-1:0]   mag_r;
  logic [NLANE-1:0]           neg_r;
  logic                       wide_r;
  logic [CW-1:0]              wmag;

  logic [IW-1:0]              hw_r;
  logic [IW-1:0]              idx_nxt;
  logic                       code_zero;

  logic [NSTG-1:0]            vld_r;
  logic [NSTG-1:0]            en;
  logic [LSTG-1:0]            kind_r;
  logic [IW-1:0]              idxp_r [LSTG];

  op_t                        op;
  logic                       in_xfer;
  logic                       has_result;

  lane_ctl_t                  lctl;
  merge_ctl_t                 mctl;
  logic [NLANE-1:0][QW-1:0]   codes;
  logic [NLANE-1:0][QUOW-1:0] quo;
  logic [NLANE-1:0][CW-1:0]   coord;
  logic                       kind_out;
  logic [IW-1:0]              idx_out;

  assign op         = op_t'(in_tuser);
  assign in_xfer    = in_tvalid && in_tready;
  assign has_result = (op == OP_VERTEX) || (op == OP_INDEX);

  // configuration registers, spans kept as sign and magnitude
  assign wmag = cfg_wdata[CW-1] ? (~cfg_wdata + CW'(1)) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      mag_r  <= '0;
      neg_r  <= '0;
      wide_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_X_OFF:  off_r[0] <= cfg_wdata;
        CFG_Y_OFF:  off_r[1] <= cfg_wdata;
        CFG_Z_OFF:  off_r[2] <= cfg_wdata;
        CFG_X_SPAN: begin
          mag_r[0] <= wmag;
          neg_r[0] <= cfg_wdata[CW-1];
        end
        CFG_Y_SPAN: begin
          mag_r[1] <= wmag;
          neg_r[1] <= cfg_wdata[CW-1];
        end
        CFG_Z_SPAN: begin
          mag_r[2] <= wmag;
          neg_r[2] <= cfg_wdata[CW-1];
        end
        CFG_WIDE:   wide_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // high-water-mark index decode
  always_comb begin
    if (wide_r) begin
      idx_nxt   = hw_r - in_tdata[79:48];
      code_zero = (in_tdata[79:48] == '0);
    end else begin
      idx_nxt   = {16'b0, hw_r[15:0] - in_tdata[63:48]};
      code_zero = (in_tdata[63:48] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
    end else if (in_xfer && op == OP_TILE) begin
      hw_r <= '0;
    end else if (in_xfer && op == OP_INDEX && code_zero) begin
      hw_r <= wide_r ? (hw_r + IW'(1)) : {16'b0, hw_r[15:0] + 16'd1};
    end
  end

  // per-stage advance, from the output side back to the input
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_xfer && has_result;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // kind and index travel beside the lanes
  always_ff @(posedge clk) begin
    if (en[0]) begin
      kind_r[0] <= (op == OP_INDEX) ? KIND_INDEX : KIND_VERTEX;
      idxp_r[0] <= idx_nxt;
    end
    for (int k = 1; k < LSTG; k++) begin
      if (en[k]) begin
        kind_r[k] <= kind_r[k-1];
        idxp_r[k] <= idxp_r[k-1];
      end
    end
  end

  // coordinate lanes
  assign lctl.step  = in_xfer && (op == OP_VERTEX);
  assign lctl.clear = in_xfer && (op == OP_TILE);
  assign lctl.en    = en[LSTG-1:0];

  assign codes[0] = in_tdata[15:0];
  assign codes[1] = in_tdata[31:16];
  assign codes[2] = in_tdata[47:32];

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    qmd_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lctl),
      .code     (codes[g]),
      .span_mag (mag_r[g]),
      .quo      (quo[g])
    );
  end

  // merging stage and output register
  assign mctl.en   = en[NSTG-1];
  assign mctl.kind = kind_r[LSTG-1];
  assign mctl.idx  = idxp_r[LSTG-1];

  qmd_merge u_merge (
    .clk   (clk),
    .ctl   (mctl),
    .quo   (quo),
    .neg   (neg_r),
    .off   (off_r),
    .kind  (kind_out),
    .coord (coord),
    .idx   (idx_out)
  );

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tuser  = kind_out;
  assign out_tdata  = {idx_out, coord[2], coord[1], coord[0]};

endmodule

[tb/quantized_mesh_decoder_core_tb.sv]
module quantized_mesh_decoder_core_tb;
  import qmd_pkg::*;

  // address past the last register, writes there must be dropped
  localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd7;
  localparam int               WAIT_MAX   = 12;
  localparam int               FLUSH_WAIT = 20;   // beyond the seven-stage pipeline
  localparam int               PRINT_MAX  = 40;
  localparam logic [CW-1:0]    TOP48      = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]    BOTTOM48   = {1'b1, {(CW-1){1'b0}}};

  typedef enum int {REGS_TOP, REGS_BOTTOM, REGS_ANY, REGS_TYPICAL} reg_style_t;

  typedef struct {
    logic          kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [IW-1:0] idx;
  } mesh_result_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [79:0]       in_tdata  = '0;   // u_code, v_code, h_code, index_code
  logic [1:0]        in_tuser  = '0;   // opcode
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [175:0]      out_tdata;        // x_out, y_out, z_out, vertex_index
  logic              out_tuser;        // kind
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = '0;
  logic [CW-1:0]     cfg_wdata = '0;

  quantized_mesh_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of registers and decoder state
  logic [CW-1:0] tile_offset [3];
  logic [CW-1:0] tile_span [3];
  logic          wide_mode;
  logic [QW-1:0] coord_accum [3];
  logic [IW-1:0] high_water;

  mesh_result_t pending_decodes [$];
  int           error_count = 0;
  int           stall_left  = 0;
  bit           calm        = 1'b0;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic logic [CW-1:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  // zigzag code back to a two's complement delta
  function automatic logic [QW-1:0] zigzag_delta(logic [QW-1:0] c);
    return c[0] ? ~(c >> 1) : (c >> 1);
  endfunction

  // offset + span*q/32767, magnitude rounded to nearest, clamped to 48 bits
  function automatic logic [CW-1:0] place_coord(logic [CW-1:0] off_bits,
                                                logic [CW-1:0] span_bits,
                                                logic [QW-1:0] q);
    longint          off, span, part, sum, hi, lo;
    longint unsigned mag, quo;
    off  = {{(64-CW){off_bits[CW-1]}}, off_bits};
    span = {{(64-CW){span_bits[CW-1]}}, span_bits};
    hi   = (longint'(1) << (CW - 1)) - 1;
    lo   = -(longint'(1) << (CW - 1));
    mag  = (span < 0) ? -span : span;
    quo  = (mag * q + QHALF) / QMAX;
    part = (span < 0) ? -longint'(quo) : longint'(quo);
    sum  = off + part;
    if (sum > hi) sum = hi;
    if (sum < lo) sum = lo;
    return sum[CW-1:0];
  endfunction

  // state update and expected result for one accepted transfer
  function automatic void decode_item(op_t op, logic [QW-1:0] u, logic [QW-1:0] v,
                                      logic [QW-1:0] h, logic [IW-1:0] code);
    mesh_result_t  r;
    logic [QW-1:0] h16;
    r = '{kind: KIND_VERTEX, x: '0, y: '0, z: '0, idx: '0};
    case (op)
      OP_TILE: begin
        coord_accum = '{default: '0};
        high_water  = '0;
      end
      OP_VERTEX: begin
        coord_accum[0] += zigzag_delta(u);
        coord_accum[1] += zigzag_delta(v);
        coord_accum[2] += zigzag_delta(h);
        r.x = place_coord(tile_offset[0], tile_span[0], coord_accum[0]);
        r.y = place_coord(tile_offset[1], tile_span[1], coord_accum[1]);
        r.z = place_coord(tile_offset[2], tile_span[2], coord_accum[2]);
        pending_decodes = {pending_decodes, r};
      end
      OP_INDEX: begin
        r.kind = KIND_INDEX;
        if (wide_mode) begin
          r.idx = high_water - code;
          if (code == '0) high_water = high_water + 1;
        end else begin
          h16   = high_water[QW-1:0];
          r.idx = {16'b0, QW'(h16 - code[QW-1:0])};
          if (code[QW-1:0] == '0) high_water = {16'b0, QW'(h16 + 1'b1)};
        end
        pending_decodes = {pending_decodes, r};
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_MAX)
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // one input transfer after a random gap
  task automatic send_item(op_t op, logic [QW-1:0] u, logic [QW-1:0] v,
                           logic [QW-1:0] h, logic [IW-1:0] code);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {code, h, v, u};
    do @(posedge clk); while (!in_tready);
    decode_item(op, u, v, h, code);
  endtask

  // idle the input and let every expected result come out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (FLUSH_WAIT) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_AW-1:0] addr, logic [CW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      CFG_X_OFF:  tile_offset[0] = data;
      CFG_Y_OFF:  tile_offset[1] = data;
      CFG_Z_OFF:  tile_offset[2] = data;
      CFG_X_SPAN: tile_span[0]   = data;
      CFG_Y_SPAN: tile_span[1]   = data;
      CFG_Z_SPAN: tile_span[2]   = data;
      CFG_WIDE:   wide_mode      = data[0];
      default: ;
    endcase
  endtask

  // all registers plus a stray write past the last one
  task automatic load_regs(logic [CW-1:0] xo, logic [CW-1:0] yo, logic [CW-1:0] zo,
                           logic [CW-1:0] xs, logic [CW-1:0] ys, logic [CW-1:0] zs,
                           logic wide);
    put_reg(CFG_X_OFF, xo);
    put_reg(CFG_Y_OFF, yo);
    put_reg(CFG_Z_OFF, zo);
    put_reg(CFG_X_SPAN, xs);
    put_reg(CFG_Y_SPAN, ys);
    put_reg(CFG_Z_SPAN, zs);
    put_reg(CFG_WIDE, {47'(rand48() >> 1), wide});
    put_reg(CFG_UNUSED, rand48());
    cfg_we <= 1'b0;
  endtask

  // result side: compare each transfer, then draw the next stall
  always @(posedge clk) begin : check_results
    mesh_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[63:0], '0);
        end else begin
          want = pending_decodes.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch("kind", 64'(out_tuser), 64'(want.kind));
          if (out_tdata[47:0] !== want.x)
            report_mismatch("x_out", 64'(out_tdata[47:0]), 64'(want.x));
          if (out_tdata[95:48] !== want.y)
            report_mismatch("y_out", 64'(out_tdata[95:48]), 64'(want.y));
          if (out_tdata[143:96] !== want.z)
            report_mismatch("z_out", 64'(out_tdata[143:96]), 64'(want.z));
          if (out_tdata[175:144] !== want.idx)
            report_mismatch("vertex_index", 64'(out_tdata[175:144]), 64'(want.idx));
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // registers still at reset: every position decodes to zero
  task automatic test_reset_defaults();
    send_item(OP_VERTEX, 16'hFFFF, 16'h0001, 16'h1234, '0);
    send_item(OP_VERTEX, 16'h0002, 16'hFFFE, 16'h8000, '0);
    send_item(OP_INDEX, '0, '0, '0, 32'h0000_0000);
    send_item(OP_INDEX, '0, '0, '0, 32'h0001_0003);
  endtask

  // saturation both ways, full-scale and zero q, rounding, ignored opcode
  task automatic test_vertex_extremes();
    settle();
    load_regs(TOP48, BOTTOM48, '0, TOP48, BOTTOM48, TOP48, 1'b0);
    send_item(OP_TILE, '0, '0, '0, '0);
    send_item(OP_VERTEX, 16'h0001, 16'h0001, 16'h0000, '0);
    send_item(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_VERTEX, 16'hFFFF, 16'hFFFE, 16'h0002, '0);
    send_item(OP_VERTEX, 16'h0000, 16'h0000, 16'h0000, '0);
    settle();
    load_regs(48'h0000_0000_0000, 48'hFFFF_FFFF_0000, 48'h0000_0001_0000,
              48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_7FFF, 1'b1);
    send_item(OP_TILE, '0, '0, '0, '0);
    send_item(OP_VERTEX, 16'd32766, 16'd32768, 16'hFFFF, '0);
    send_item(OP_VERTEX, 16'd2, 16'd1, 16'd3, '0);
    send_item(OP_VERTEX, 16'hFFFE, 16'h7FFF, 16'h8001, '0);
  endtask

  // high-water mark in both widths, upper code bits, tile start clearing it
  task automatic test_index_modes();
    settle();
    load_regs(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), 1'b0);
    send_item(OP_TILE, '0, '0, '0, '0);
    send_item(OP_INDEX, '0, '0, '0, 32'h0000_0000);
    send_item(OP_INDEX, '0, '0, '0, 32'h0000_0000);
    send_item(OP_INDEX, '0, '0, '0, 32'hFFFF_0000);
    send_item(OP_INDEX, '0, '0, '0, 32'h0000_0005);
    send_item(OP_INDEX, '0, '0, '0, 32'h0000_FFFF);
    settle();
    load_regs(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), 1'b1);
    send_item(OP_INDEX, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_INDEX, '0, '0, '0, 32'h0000_0000);
    send_item(OP_INDEX, '0, '0, '0, 32'h8000_0000);
    send_item(OP_TILE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_INDEX, '0, '0, '0, 32'h0000_0000);
  endtask

  // count the mark up in wide mode, then step it in narrow mode and back
  task automatic test_mark_mode_switch();
    settle();
    load_regs(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), 1'b1);
    send_item(OP_TILE, '0, '0, '0, '0);
    repeat (8)
      send_item(OP_INDEX, 16'($urandom()), 16'($urandom()), 16'($urandom()), '0);
    settle();
    load_regs(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), 1'b0);
    send_item(OP_INDEX, '0, '0, '0, {16'($urandom()), 16'h0000});
    send_item(OP_INDEX, '0, '0, '0, 32'h0000_0009);
    settle();
    load_regs(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), 1'b1);
    send_item(OP_INDEX, '0, '0, '0, 32'h0001_0000);
    send_item(OP_INDEX, '0, '0, '0, 32'h0000_0000);
  endtask

  // mostly well-formed tiles with random content, some noise
  task automatic test_random_stream(int n_items, reg_style_t style);
    int            count;
    int            pick;
    op_t           op;
    logic [QW-1:0] code [3];
    logic [IW-1:0] index_code;
    settle();
    case (style)
      REGS_TOP:    load_regs(TOP48, TOP48, TOP48, TOP48, TOP48, TOP48, 1'b1);
      REGS_BOTTOM: load_regs(BOTTOM48, BOTTOM48, BOTTOM48,
                             BOTTOM48, BOTTOM48, BOTTOM48, 1'b0);
      REGS_ANY:    load_regs(rand48(), rand48(), rand48(), rand48(), rand48(),
                             rand48(), 1'($urandom()));
      default:     load_regs(CW'($signed(41'($urandom_range(0, 1 << 20) << 20))),
                             CW'($signed(41'($urandom_range(0, 1 << 20) << 20))),
                             CW'($signed(41'($urandom_range(0, 1 << 20) << 20))),
                             CW'(36'($urandom_range(1, 1 << 30) << 6)),
                             CW'(36'($urandom_range(1, 1 << 30) << 6)),
                             CW'(36'($urandom_range(1, 1 << 30) << 6)),
                             1'($urandom()));
    endcase
    count = 0;
    while (count < n_items) begin
      if (count % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55)      op = OP_VERTEX;
      else if (pick < 85) op = OP_INDEX;
      else if (pick < 90) op = OP_TILE;
      else                op = OP_NONE;
      // small deltas like a real tile, sometimes full-range codes
      for (int i = 0; i < 3; i++)
        code[i] = $urandom_range(0, 1) ? 16'($urandom_range(0, 63)) : 16'($urandom());
      pick = $urandom_range(0, 9);
      if (pick < 4)      index_code = '0;
      else if (pick < 8) index_code = $urandom_range(1, 16);
      else               index_code = $urandom();
      send_item(op, code[0], code[1], code[2], index_code);
      if (op != OP_NONE) count++;
    end
    calm = 1'b0;
  endtask

  initial begin
    tile_offset = '{default: '0};
    tile_span   = '{default: '0};
    wide_mode   = 1'b0;
    coord_accum = '{default: '0};
    high_water  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_vertex_extremes();
    test_index_modes();
    test_mark_mode_switch();
    test_random_stream(400, REGS_TYPICAL);
    test_random_stream(300, REGS_TOP);
    test_random_stream(300, REGS_BOTTOM);
    test_random_stream(500, REGS_ANY);
    test_random_stream(500, REGS_TYPICAL);
    settle();
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // hard stop if the stream stalls for good
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
